>>> sv/mbpt_pkg.sv
// shared types and message codes for the bank and program tracker
package mbpt_pkg;

    localparam logic [3:0] MT_MIDI1 = 4'h2;
    localparam logic [3:0] MT_MIDI2 = 4'h4;
    localparam logic [3:0] ST_CC    = 4'hB;
    localparam logic [3:0] ST_PC    = 4'hC;

    localparam logic [6:0] CTL_BANK_MSB = 7'd0;
    localparam logic [6:0] CTL_BANK_LSB = 7'd32;

    typedef struct packed {
        logic [6:0] pending_high;
        logic [6:0] pending_low;
        logic [6:0] held_bank_high;
        logic [6:0] held_bank_low;
        logic [6:0] held_program;
        logic       seen;
    } track_state_t;

    typedef struct packed {
        logic       selection_changed;
        logic [6:0] bank_high;
        logic [6:0] bank_low;
        logic [6:0] program_number;
        logic       program_valid;
    } track_result_t;

endpackage

>>> sv/midi_bank_program_tracker.sv
// top level of the bank select and program change tracker
// One Universal MIDI Packet (two words) in per transfer, one result out per packet.
// Packets go through an input register and a result register, with the tracker
// state updated as a packet moves into the result register, so a new packet is
// taken every cycle while the result side does not stall. Bank MSB/LSB control
// changes on MIDI 1.0 and MIDI 2.0 channel voice packets are held as pending; a
// program change forms the selection, flags whether it is the first or differs
// from the held one, and every result carries the held selection and whether
// any program change has been seen.
module midi_bank_program_tracker
    import mbpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        packet_valid,
    output logic        packet_stall,
    input  logic [31:0] first_word,
    input  logic [31:0] second_word,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        selection_changed,
    output logic [6:0]  bank_high,
    output logic [6:0]  bank_low,
    output logic [6:0]  program_number,
    output logic        program_valid
);

    logic          pkt_valid_reg;
    logic [31:0]   word0_reg;
    logic [31:0]   word1_reg;
    logic          res_valid_reg;
    track_result_t res_reg;
    track_state_t  state_reg;
    track_state_t  state_next;
    track_result_t res_next;
    logic          res_open;
    logic          advance;
    logic          take_packet;

    mbpt_update u_update
    (
        .first_word  (word0_reg),
        .second_word (word1_reg),
        .cur_state   (state_reg),
        .nxt_state   (state_next),
        .result      (res_next)
    );

    assign res_open     = !res_valid_reg || !result_stall;
    assign advance      = pkt_valid_reg && res_open;
    assign packet_stall = pkt_valid_reg && !res_open;
    assign take_packet  = packet_valid && !packet_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (take_packet)
            begin
                pkt_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                pkt_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_packet)
        begin
            word0_reg <= first_word;
            word1_reg <= second_word;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid      = res_valid_reg;
    assign selection_changed = res_reg.selection_changed;
    assign bank_high         = res_reg.bank_high;
    assign bank_low          = res_reg.bank_low;
    assign program_number    = res_reg.program_number;
    assign program_valid     = res_reg.program_valid;

    a_changed_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && selection_changed |-> program_valid)
        else $error("change flagged without a program change");

    a_zero_before_seen: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !program_valid |->
            (bank_high == 7'd0) && (bank_low == 7'd0) && (program_number == 7'd0))
        else $error("held selection nonzero before first program change");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(state_reg.seen))
        else $error("seen flag cleared");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        packet_stall |-> pkt_valid_reg && res_valid_reg && result_stall)
        else $error("packet stalled while pipeline can move");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("tracker state changed without a packet");

endmodule

>>> sv/mbpt_update.sv
// packet decode and next tracker state for one packet
module mbpt_update
    import mbpt_pkg::*;
(
    input  logic [31:0]   first_word,
    input  logic [31:0]   second_word,
    input  track_state_t  cur_state,
    output track_state_t  nxt_state,
    output track_result_t result
);

    logic [3:0] msg_type;
    logic [3:0] status;
    logic [6:0] ctl;
    logic [6:0] cc_value;
    logic       is_midi2;
    logic       is_voice;
    logic [6:0] new_high;
    logic [6:0] new_low;
    logic [6:0] new_program;
    logic       changed;

    assign msg_type = first_word[31:28];
    assign status   = first_word[23:20];
    assign ctl      = first_word[14:8];
    assign is_midi2 = (msg_type == MT_MIDI2);
    assign is_voice = (msg_type == MT_MIDI1) || is_midi2;
    assign cc_value = is_midi2 ? second_word[31:25] : first_word[6:0];

    always_comb
    begin
        nxt_state   = cur_state;
        changed     = 1'b0;
        new_high    = cur_state.pending_high;
        new_low     = cur_state.pending_low;
        new_program = first_word[14:8];
        if (is_midi2)
        begin
            new_program = second_word[30:24];
            if (first_word[0])
            begin
                new_high = second_word[14:8];
                new_low  = second_word[6:0];
            end
        end
        if (is_voice)
        begin
            case (status)
                ST_CC:
                begin
                    if (ctl == CTL_BANK_MSB)
                    begin
                        nxt_state.pending_high = cc_value;
                    end
                    else if (ctl == CTL_BANK_LSB)
                    begin
                        nxt_state.pending_low = cc_value;
                    end
                end
                ST_PC:
                begin
                    changed = !cur_state.seen
                           || (new_high != cur_state.held_bank_high)
                           || (new_low != cur_state.held_bank_low)
                           || (new_program != cur_state.held_program);
                    nxt_state.pending_high   = new_high;
                    nxt_state.pending_low    = new_low;
                    nxt_state.held_bank_high = new_high;
                    nxt_state.held_bank_low  = new_low;
                    nxt_state.held_program   = new_program;
                    nxt_state.seen           = 1'b1;
                end
                default:
                begin
                    nxt_state = cur_state;
                end
            endcase
        end
    end

    assign result.selection_changed = changed;
    assign result.bank_high         = nxt_state.held_bank_high;
    assign result.bank_low          = nxt_state.held_bank_low;
    assign result.program_number    = nxt_state.held_program;
    assign result.program_valid     = nxt_state.seen;

endmodule

>>> verif/tb.sv
// testbench for midi_bank_program_tracker: directed and random packet stream checked against a predictor
module tb;
    import mbpt_pkg::*;

    localparam int RANDOM_PACKETS = 1628;
    localparam int QUIET_LIMIT    = 1500;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 80;
    localparam int CALM_TAIL      = 200;

    typedef struct packed {
        logic [31:0] word0;
        logic [31:0] word1;
    } packet_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        packet_valid = 1'b0;
    logic        packet_stall;
    logic [31:0] first_word = '0;
    logic [31:0] second_word = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        selection_changed;
    logic [6:0]  bank_high;
    logic [6:0]  bank_low;
    logic [6:0]  program_number;
    logic        program_valid;

    packet_t       packet_q[$];
    track_result_t selection_q[$];

    logic [6:0] pend_msb = '0;
    logic [6:0] pend_lsb = '0;
    logic [6:0] cur_msb = '0;
    logic [6:0] cur_lsb = '0;
    logic [6:0] cur_prog = '0;
    logic       cur_seen = 1'b0;

    int errors = 0;
    int results_seen = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    midi_bank_program_tracker DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .packet_valid      (packet_valid),
        .packet_stall      (packet_stall),
        .first_word        (first_word),
        .second_word       (second_word),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .selection_changed (selection_changed),
        .bank_high         (bank_high),
        .bank_low          (bank_low),
        .program_number    (program_number),
        .program_valid     (program_valid)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    // bank and program state update for one packet transfer
    task automatic track_packet(input logic [31:0] w0, input logic [31:0] w1);
        logic [3:0]    mt;
        logic [3:0]    st;
        logic [6:0]    ctl;
        logic [6:0]    val;
        logic [6:0]    np;
        logic          changed;
        track_result_t sel;
        mt = w0[31:28];
        st = w0[23:20];
        changed = 1'b0;
        if (mt == MT_MIDI1 || mt == MT_MIDI2)
        begin
            if (st == ST_CC)
            begin
                ctl = w0[14:8];
                val = (mt == MT_MIDI2) ? w1[31:25] : w0[6:0];
                if (ctl == CTL_BANK_MSB)
                    pend_msb = val;
                else if (ctl == CTL_BANK_LSB)
                    pend_lsb = val;
            end
            else if (st == ST_PC)
            begin
                if (mt == MT_MIDI2)
                begin
                    np = w1[30:24];
                    if (w0[0])
                    begin
                        pend_msb = w1[14:8];
                        pend_lsb = w1[6:0];
                    end
                end
                else
                begin
                    np = w0[14:8];
                end
                changed = !cur_seen || pend_msb != cur_msb || pend_lsb != cur_lsb
                          || np != cur_prog;
                cur_msb = pend_msb;
                cur_lsb = pend_lsb;
                cur_prog = np;
                cur_seen = 1'b1;
            end
        end
        sel.selection_changed = changed;
        sel.bank_high = cur_msb;
        sel.bank_low = cur_lsb;
        sel.program_number = cur_prog;
        sel.program_valid = cur_seen;
        selection_q.push_back(sel);
    endtask

    function automatic packet_t voice(input logic [3:0] mt, input logic [3:0] st);
        packet_t p;
        p.word0 = $urandom;
        p.word1 = $urandom;
        p.word0[31:28] = mt;
        p.word0[23:20] = st;
        return p;
    endfunction

    function automatic packet_t control_change(input logic [3:0] mt, input logic [6:0] ctl,
                                               input logic [6:0] val);
        packet_t p;
        p = voice(mt, ST_CC);
        p.word0[14:8] = ctl;
        if (mt == MT_MIDI2)
            p.word1[31:25] = val;
        else
            p.word0[6:0] = val;
        return p;
    endfunction

    function automatic packet_t program_change1(input logic [6:0] prog);
        packet_t p;
        p = voice(MT_MIDI1, ST_PC);
        p.word0[14:8] = prog;
        return p;
    endfunction

    function automatic packet_t program_change2(input logic bv, input logic [6:0] msb,
                                                input logic [6:0] lsb, input logic [6:0] prog);
        packet_t p;
        p = voice(MT_MIDI2, ST_PC);
        p.word0[0] = bv;
        p.word1[30:24] = prog;
        p.word1[14:8] = msb;
        p.word1[6:0] = lsb;
        return p;
    endfunction

    // small value pool so that repeated selections are common
    function automatic logic [6:0] pick7();
        case ($urandom_range(0, 5))
            0: return 7'd0;
            1: return 7'd127;
            2: return 7'd1;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic bit may_idle();
        return packet_q.size() >= CALM_TAIL && ((packet_q.size() / 128) % 3) != 0
               && hold_left == 0;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        packet_t p;
        if (!rst_n)
        begin
            packet_valid <= 1'b0;
            first_word <= '0;
            second_word <= '0;
            gap_left = 0;
        end
        else
        begin
            if (packet_valid && !packet_stall)
                track_packet(first_word, second_word);
            if (!packet_valid || !packet_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    packet_valid <= 1'b0;
                end
                else if (packet_q.size() == 0)
                begin
                    packet_valid <= 1'b0;
                end
                else if (may_idle() && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(0, 10);
                    packet_valid <= 1'b0;
                end
                else
                begin
                    p = packet_q.pop_front();
                    first_word <= p.word0;
                    second_word <= p.word1;
                    packet_valid <= 1'b1;
                end
            end
        end
    end

    // receiver, with one long hold-off to back up the pipeline
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (may_idle() && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin : check_proc
        track_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (selection_q.size() == 0)
            begin
                report_mismatch("result transfer with nothing expected");
            end
            else
            begin
                want = selection_q.pop_front();
                if (selection_changed !== want.selection_changed)
                    report_mismatch($sformatf("selection_changed got %0b want %0b",
                                              selection_changed, want.selection_changed));
                if (bank_high !== want.bank_high)
                    report_mismatch($sformatf("bank_high got %0d want %0d",
                                              bank_high, want.bank_high));
                if (bank_low !== want.bank_low)
                    report_mismatch($sformatf("bank_low got %0d want %0d",
                                              bank_low, want.bank_low));
                if (program_number !== want.program_number)
                    report_mismatch($sformatf("program_number got %0d want %0d",
                                              program_number, want.program_number));
                if (program_valid !== want.program_valid)
                    report_mismatch($sformatf("program_valid got %0b want %0b",
                                              program_valid, want.program_valid));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((packet_valid && !packet_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        packet_t p;
        packet_t last_pc;
        logic [3:0] mt;
        int k;

        // directed packets
        packet_q.push_back(program_change1(7'd0));
        packet_q.push_back(program_change1(7'd0));
        packet_q.push_back(control_change(MT_MIDI1, CTL_BANK_MSB, 7'd127));
        packet_q.push_back(control_change(MT_MIDI1, CTL_BANK_LSB, 7'd127));
        packet_q.push_back(program_change1(7'd127));
        p = control_change(MT_MIDI1, CTL_BANK_MSB, 7'd5);
        p.word0[15] = 1'b1;
        packet_q.push_back(p);
        packet_q.push_back(control_change(MT_MIDI1, 7'd64, 7'd99));
        packet_q.push_back(program_change1(7'd127));
        packet_q.push_back(control_change(MT_MIDI2, CTL_BANK_MSB, 7'd127));
        packet_q.push_back(control_change(MT_MIDI2, CTL_BANK_LSB, 7'd0));
        packet_q.push_back(program_change2(1'b0, 7'd3, 7'd3, 7'd5));
        packet_q.push_back(program_change2(1'b0, 7'd9, 7'd9, 7'd5));
        packet_q.push_back(program_change2(1'b1, 7'd127, 7'd0, 7'd127));
        packet_q.push_back(program_change1(7'd127));
        packet_q.push_back(program_change2(1'b1, 7'd0, 7'd127, 7'd0));
        packet_q.push_back(program_change1(7'd0));
        packet_q.push_back(voice(4'h3, ST_PC));
        packet_q.push_back(voice(MT_MIDI1, 4'h9));
        packet_q.push_back(voice(MT_MIDI2, 4'hE));
        packet_q.push_back('0);
        packet_q.push_back('1);
        packet_q.push_back(program_change1(7'd42));
        last_pc = program_change1(7'd42);

        for (int i = 0; i < RANDOM_PACKETS; i++)
        begin
            k = $urandom_range(0, 99);
            mt = $urandom_range(0, 1) ? MT_MIDI2 : MT_MIDI1;
            if (k < 30)
            begin
                p = control_change(mt, $urandom_range(0, 1) ? CTL_BANK_LSB : CTL_BANK_MSB,
                                   pick7());
            end
            else if (k < 45)
            begin
                p = program_change1(pick7());
                last_pc = p;
            end
            else if (k < 62)
            begin
                p = program_change2(1'($urandom_range(0, 1)), pick7(), pick7(), pick7());
                last_pc = p;
            end
            else if (k < 70)
            begin
                p = last_pc;
            end
            else if (k < 80)
            begin
                p = control_change(mt, 7'($urandom_range(0, 127)), pick7());
            end
            else if (k < 90)
            begin
                p = voice(mt, 4'($urandom_range(0, 15)));
            end
            else
            begin
                p.word0 = $urandom;
                p.word1 = $urandom;
            end
            packet_q.push_back(p);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (packet_q.size() != 0 || packet_valid || selection_q.size() != 0);
        repeat (8) @(negedge clk);

        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
